/* rtl/utf8_stream_validator_top_macros.svh */
// Assertion macros shared by the UTF-8 stream validator RTL.
`ifndef UTF8_STREAM_VALIDATOR_TOP_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define UTF8SV_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("utf8 validator: same-cycle check failed");

// Next-cycle implication.
`define UTF8SV_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("utf8 validator: next-cycle check failed");

`else

`define UTF8SV_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define UTF8SV_ASSERT_NXT(lbl, ck, rs, ante, cons)

`endif

`endif

/* rtl/utf8sv_pkg.sv */
// Types, constants and decode functions for the UTF-8 stream validator.
package utf8sv_pkg;

  localparam logic [7:0] CONT_PREFIX_MASK = 8'hC0;
  localparam logic [7:0] CONT_PREFIX      = 8'h80;
  localparam logic [7:0] TWO_BYTE_PAYLOAD = 8'h1E;

  // Input register contents.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_string;
  } stage_t;

  // Verdict handed from the checker to the result register.
  typedef struct packed {
    logic load;
    logic is_valid;
  } verdict_t;

  // Leading ones of a byte, 0..8.
  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    case (b) inside
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

  // High payload bits the first continuation byte must carry when the
  // lead payload is all zero.
  function automatic logic [7:0] first_cont_mask(input logic [2:0] len);
    logic [7:0] m;
    case (len)
      3'd3:    m = 8'h20;
      3'd4:    m = 8'h30;
      3'd5:    m = 8'h38;
      3'd6:    m = 8'h3C;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

/* rtl/utf8sv_in_reg.sv */
// Input register stage of the UTF-8 stream validator.
module utf8sv_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         data_byte,
  input  logic               byte_present,
  input  logic               end_of_string,
  input  logic               advance,
  output logic               in_stall,
  output utf8sv_pkg::stage_t stage
);
  import utf8sv_pkg::*;

  logic load;

  assign in_stall = stage.valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (!in_stall) begin
      stage.valid <= in_valid;
    end
    if (load) begin
      stage.data_byte     <= data_byte;
      stage.byte_present  <= byte_present;
      stage.end_of_string <= end_of_string;
    end
  end

endmodule

/* rtl/utf8sv_check.sv */
// Per-byte UTF-8 sequence checker with string state.
`include "utf8_stream_validator_top_macros.svh"

module utf8sv_check (
  input  logic                 clk,
  input  logic                 rst,
  input  utf8sv_pkg::stage_t   stage,
  input  logic                 advance,
  output utf8sv_pkg::verdict_t verdict
);
  import utf8sv_pkg::*;

  logic [2:0] bytes_pending, bytes_pending_next;
  logic [2:0] sequence_length, sequence_length_next;
  logic       range_check_due, range_check_due_next;
  logic       failed, failed_next;

  always_comb begin
    logic [3:0] ones;
    logic [2:0] pend_a;
    logic [2:0] len_a;
    logic       rcd_a;
    logic       fail_a;
    ones   = lead_ones(stage.data_byte);
    pend_a = bytes_pending;
    len_a  = sequence_length;
    rcd_a  = range_check_due;
    fail_a = failed;
    if (stage.byte_present && !failed) begin
      if (bytes_pending != 3'd0) begin
        if ((stage.data_byte & CONT_PREFIX_MASK) != CONT_PREFIX) begin
          fail_a = 1'b1;
        end else if (range_check_due &&
                     (stage.data_byte & first_cont_mask(sequence_length)) == 8'h00) begin
          rcd_a  = 1'b0;
          fail_a = 1'b1;
        end else begin
          rcd_a  = 1'b0;
          pend_a = bytes_pending - 3'd1;
          if (bytes_pending == 3'd1) begin
            len_a = 3'd0;
          end
        end
      end else begin
        rcd_a = 1'b0;
        case (ones) inside
          4'd0: begin
          end
          4'd2: begin
            if ((stage.data_byte & TWO_BYTE_PAYLOAD) == 8'h00) begin
              fail_a = 1'b1;
            end else begin
              len_a  = 3'd2;
              pend_a = 3'd1;
            end
          end
          [4'd3:4'd6]: begin
            rcd_a  = (stage.data_byte & (8'hFF >> ones)) == 8'h00;
            len_a  = ones[2:0];
            pend_a = ones[2:0] - 3'd1;
          end
          default: begin
            fail_a = 1'b1;
          end
        endcase
      end
    end

    verdict.load     = advance && stage.end_of_string;
    verdict.is_valid = !fail_a && (pend_a == 3'd0);

    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    range_check_due_next = range_check_due;
    failed_next          = failed;
    if (advance) begin
      if (stage.end_of_string) begin
        // Close the string: clear everything.
        bytes_pending_next   = 3'd0;
        sequence_length_next = 3'd0;
        range_check_due_next = 1'b0;
        failed_next          = 1'b0;
      end else begin
        bytes_pending_next   = pend_a;
        sequence_length_next = len_a;
        range_check_due_next = rcd_a;
        failed_next          = fail_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= 3'd0;
      sequence_length <= 3'd0;
      range_check_due <= 1'b0;
      failed          <= 1'b0;
    end else begin
      bytes_pending   <= bytes_pending_next;
      sequence_length <= sequence_length_next;
      range_check_due <= range_check_due_next;
      failed          <= failed_next;
    end
  end

  `UTF8SV_ASSERT_IMP(a_idle_no_len, clk, rst, bytes_pending == 3'd0, sequence_length == 3'd0)
  `UTF8SV_ASSERT_IMP(a_pend_below_len, clk, rst, bytes_pending != 3'd0, bytes_pending < sequence_length)
  `UTF8SV_ASSERT_IMP(a_rcd_long_only, clk, rst, range_check_due, sequence_length >= 3'd3)
  `UTF8SV_ASSERT_NXT(a_eos_clears, clk, rst, verdict.load, !failed && bytes_pending == 3'd0)

endmodule

/* rtl/utf8sv_out_reg.sv */
// Result register of the UTF-8 stream validator.
module utf8sv_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  utf8sv_pkg::verdict_t verdict,
  input  logic                 out_stall,
  output logic                 out_free,
  output logic                 out_valid,
  output logic                 is_valid
);
  import utf8sv_pkg::*;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= verdict.load;
    end
    if (out_free && verdict.load) begin
      is_valid <= verdict.is_valid;
    end
  end

endmodule

/* rtl/utf8_stream_validator_top.sv */
// Top level of the UTF-8 stream validator (six-byte form).
// Path: the input register holds the closing item until the result register
//   is free, and the result register then takes the verdict.
// Throughput: one item per cycle; a closing item whose verdict finds the result
//   register still full waits in the input register and stalls the input.
// Reset: synchronous rst clears both stage valids and the string state.
`include "utf8_stream_validator_top_macros.svh"

module utf8_stream_validator_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_valid,
  output logic       verdict_last
);
  import utf8sv_pkg::*;

  stage_t   stage;
  verdict_t verdict;
  logic     out_free;
  logic     advance;

  // Advance the registered item: bytes that close nothing always move on,
  // a closing item waits until the result register can take its verdict.
  assign advance = stage.valid && (!stage.end_of_string || out_free);

  // Every result is the single verdict of its string.
  assign verdict_last = 1'b1;

  // Hold the incoming item in front of the checker.
  utf8sv_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .data_byte     (data_byte),
    .byte_present  (byte_present),
    .end_of_string (end_of_string),
    .advance       (advance),
    .in_stall      (in_stall),
    .stage         (stage)
  );

  // Decode lead or continuation byte, update the sticky string state.
  utf8sv_check u_check (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .verdict (verdict)
  );

  // Park the verdict until downstream drops its stall.
  utf8sv_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .verdict   (verdict),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .is_valid  (is_valid)
  );

  `UTF8SV_ASSERT_NXT(a_close_gives_verdict, clk, rst, advance && stage.end_of_string, out_valid)
  `UTF8SV_ASSERT_IMP(a_stall_needs_item, clk, rst, in_stall, stage.valid && stage.end_of_string)

endmodule
